// ===== rtl/core/interleaved_address_decoder_assert.svh =====
// assertion macros for the interleaved address decoder checker
// no dependencies
`ifndef INTERLEAVED_ADDRESS_DECODER_ASSERT_SVH
`define INTERLEAVED_ADDRESS_DECODER_ASSERT_SVH

// implication in the same cycle
`define IAD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// plain invariant
`define IAD_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/iad_pkg.sv =====
// shared types and constants for the interleaved address decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package iad_pkg;

    localparam int ADDR_WIDTH_DEF = 64;
    localparam int LOCAL_W        = 53;
    localparam int PAGE_W         = 43;
    localparam int SIZE_W         = 13;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_START     = 3'd0,
        REG_MEM_SIZE        = 3'd1,
        REG_INTERLEAVE_SIZE = 3'd2,
        REG_INTERLEAVE_STEP = 3'd3,
        REG_PAGE_COUNT      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0]        request_address;
        logic [SIZE_W-1:0]  access_size;
    } request_t;

    typedef struct packed {
        logic               in_range;
        logic [LOCAL_W-1:0] local_address;
        logic               overrun;
    } result_t;

    // travels alongside the divider
    typedef struct packed {
        logic [SIZE_W-1:0]  access_size;
        logic               addr_ge;
        logic               flat_hit;
        logic [LOCAL_W-1:0] dist_lo;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/iad_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on iad_pkg
`timescale 1ns / 1ps
`default_nettype none
module iad_div #(
    parameter int DW = iad_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_vld,
    input  wire logic [DW-1:0]                dividend,
    input  wire logic [iad_pkg::LOCAL_W-1:0]  divisor,
    input  wire iad_pkg::side_t               in_side,
    output logic                              out_vld,
    output logic [DW-1:0]                     quotient,
    output logic [iad_pkg::LOCAL_W-1:0]       remainder,
    output iad_pkg::side_t                    out_side
);
    import iad_pkg::*;

    logic               vld_reg  [1:DW];
    logic [DW-1:0]      dvd_reg  [1:DW];
    logic [DW-1:0]      quo_reg  [1:DW];
    logic [LOCAL_W-1:0] rem_reg  [1:DW];
    side_t              side_reg [1:DW];

    for (genvar i = 0; i < DW; i++)
    begin : g_stage
        logic               vld_src;
        logic [DW-1:0]      dvd_src;
        logic [DW-1:0]      quo_src;
        logic [LOCAL_W-1:0] rem_src;
        side_t              side_src;
        logic [LOCAL_W:0]   trial;
        logic               ge;
        logic [LOCAL_W-1:0] rem_next;

        if (i == 0)
        begin : g_head
            assign vld_src  = in_vld;
            assign dvd_src  = dividend;
            assign quo_src  = '0;
            assign rem_src  = '0;
            assign side_src = in_side;
        end
        else
        begin : g_body
            assign vld_src  = vld_reg[i];
            assign dvd_src  = dvd_reg[i];
            assign quo_src  = quo_reg[i];
            assign rem_src  = rem_reg[i];
            assign side_src = side_reg[i];
        end

        always_comb
        begin
            trial    = {rem_src, dvd_src[DW-1]};
            ge       = trial >= {1'b0, divisor};
            rem_next = ge ? LOCAL_W'(trial - {1'b0, divisor}) : trial[LOCAL_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            dvd_reg[i+1]  <= {dvd_src[DW-2:0], 1'b0};
            quo_reg[i+1]  <= {quo_src[DW-2:0], ge};
            rem_reg[i+1]  <= rem_next;
            side_reg[i+1] <= side_src;
        end
    end

    assign out_vld   = vld_reg[DW];
    assign quotient  = quo_reg[DW];
    assign remainder = rem_reg[DW];
    assign out_side  = side_reg[DW];

endmodule
`default_nettype wire

// ===== rtl/core/interleaved_address_decoder.sv =====
// top level of the interleaved address decoder
// depends on iad_pkg and iad_div
//
// channel   | handshake         | payload
// request   | start, busy       | request
// result    | done (strobe)     | result
// config    | cfg_we            | cfg_index, cfg_data
//
// one request per cycle; busy never rises
// path: stage 0, the bit-per-stage divider, stages m1 to m3, then the output register
// asynchronous reset empties the pipeline; config registers reset to zero
// the result receiver cannot stall, so nothing is held back
`timescale 1ns / 1ps
`default_nettype none
module interleaved_address_decoder #(
    parameter int ADDR_WIDTH = iad_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire iad_pkg::request_t             request,
    output logic                               done,
    output iad_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [iad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [iad_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iad_pkg::*;

    localparam int CW = (ADDR_WIDTH > PAGE_W) ? ADDR_WIDTH : PAGE_W;
    localparam int FW = (ADDR_WIDTH > LOCAL_W) ? ADDR_WIDTH : LOCAL_W;
    localparam int PW = 2 * LOCAL_W - 9 + PAGE_W;
    localparam int HA = 27;
    localparam int HB = 22;

    logic [ADDR_WIDTH-1:0] range_start_reg;
    logic [LOCAL_W-1:0]    mem_size_reg;
    logic [LOCAL_W-1:0]    isize_reg;
    logic [LOCAL_W-1:0]    istep_reg;
    logic [PAGE_W-1:0]     page_count_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= '0;
            mem_size_reg    <= '0;
            isize_reg       <= '0;
            istep_reg       <= '0;
            page_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RANGE_START:     range_start_reg <= cfg_data[ADDR_WIDTH-1:0];
                REG_MEM_SIZE:        mem_size_reg    <= cfg_data[LOCAL_W-1:0];
                REG_INTERLEAVE_SIZE: isize_reg       <= cfg_data[LOCAL_W-1:0];
                REG_INTERLEAVE_STEP: istep_reg       <= cfg_data[LOCAL_W-1:0];
                REG_PAGE_COUNT:      page_count_reg  <= cfg_data[PAGE_W-1:0];
                default:             ;
            endcase
        end
    end

    // stage 0: distance from window base
    logic                  s0_vld_reg;
    logic [ADDR_WIDTH-1:0] s0_dist_reg;
    side_t                 s0_side_reg;
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] dist_next;
    side_t                 side_next;

    always_comb
    begin
        addr                  = request.request_address[ADDR_WIDTH-1:0];
        dist_next             = addr - range_start_reg;
        side_next.access_size = request.access_size;
        side_next.addr_ge     = addr >= range_start_reg;
        side_next.flat_hit    = FW'(dist_next) < FW'(mem_size_reg);
        side_next.dist_lo     = LOCAL_W'(dist_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_dist_reg <= dist_next;
        s0_side_reg <= side_next;
    end

    logic                  dv_vld;
    logic [ADDR_WIDTH-1:0] dv_quo;
    logic [LOCAL_W-1:0]    dv_rem;
    side_t                 dv_side;

    iad_div #(
        .DW (ADDR_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (s0_vld_reg),
        .dividend  (s0_dist_reg),
        .divisor   (istep_reg),
        .in_side   (s0_side_reg),
        .out_vld   (dv_vld),
        .quotient  (dv_quo),
        .remainder (dv_rem),
        .out_side  (dv_side)
    );

    // stage m1: ownership test and partial products
    logic               m1_vld_reg;
    logic               m1_hit_reg;
    logic [LOCAL_W-1:0] m1_off_reg;
    side_t              m1_side_reg;
    logic [HB+HA-1:0]   p0_reg;
    logic [HB+HA-1:0]   p1_reg;
    logic [HB+HA-1:0]   p2_reg;
    logic [HB+HA-1:0]   p3_reg;
    logic [CW-1:0]      page_ext;
    logic [PAGE_W-1:0]  pg;
    logic               hit_next;

    always_comb
    begin
        page_ext = CW'(dv_quo);
        pg       = page_ext[PAGE_W-1:0];
        hit_next = dv_side.addr_ge && (page_count_reg != '0) && (istep_reg != '0)
                   && (isize_reg != '0) && (page_ext < CW'(page_count_reg))
                   && (dv_rem < isize_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_hit_reg  <= hit_next;
        m1_off_reg  <= dv_rem;
        m1_side_reg <= dv_side;
        p0_reg      <= (HB+HA)'({{(HA){1'b0}}, pg[HB-1:0]} * {{(HB){1'b0}}, isize_reg[HA-1:0]});
        p1_reg      <= (HB+HA)'({{(HA){1'b0}}, pg[HB-1:0]}
                                * {{(HB+1){1'b0}}, isize_reg[LOCAL_W-1:HA]});
        p2_reg      <= (HB+HA)'({{(HA+1){1'b0}}, pg[PAGE_W-1:HB]}
                                * {{(HB){1'b0}}, isize_reg[HA-1:0]});
        p3_reg      <= (HB+HA)'({{(HA+1){1'b0}}, pg[PAGE_W-1:HB]}
                                * {{(HB+1){1'b0}}, isize_reg[LOCAL_W-1:HA]});
    end

    // stage m2: pair sums
    logic          m2_vld_reg;
    logic          m2_hit_reg;
    side_t         m2_side_reg;
    logic [PW-1:0] m2_sa_reg;
    logic [PW-1:0] m2_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_vld_reg <= 1'b0;
        end
        else
        begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_hit_reg  <= m1_hit_reg;
        m2_side_reg <= m1_side_reg;
        m2_sa_reg   <= PW'(p0_reg) + (PW'(p1_reg) << HA) + PW'(m1_off_reg);
        m2_sb_reg   <= PW'(p2_reg) + (PW'(p3_reg) << HA);
    end

    // stage m3: final sum and saturation
    logic               m3_vld_reg;
    logic               m3_hit_reg;
    logic               m3_sat_reg;
    logic [LOCAL_W-1:0] m3_local_reg;
    side_t              m3_side_reg;
    logic [PW-1:0]      total;

    always_comb
    begin
        total = m2_sa_reg + (m2_sb_reg << HB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_vld_reg <= 1'b0;
        end
        else
        begin
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m3_hit_reg   <= m2_hit_reg;
        m3_side_reg  <= m2_side_reg;
        m3_sat_reg   <= |total[PW-1:LOCAL_W];
        m3_local_reg <= (|total[PW-1:LOCAL_W]) ? {LOCAL_W{1'b1}} : total[LOCAL_W-1:0];
    end

    // output stage: mode select and overrun
    logic               done_reg;
    result_t            result_reg;
    logic               flat;
    logic               in_next;
    logic               sat_next;
    logic [LOCAL_W-1:0] local_next;
    result_t            result_next;

    always_comb
    begin
        flat       = page_count_reg == '0;
        in_next    = flat ? (m3_side_reg.addr_ge && m3_side_reg.flat_hit) : m3_hit_reg;
        sat_next   = !flat && m3_sat_reg;
        local_next = !in_next ? '0 : (flat ? m3_side_reg.dist_lo : m3_local_reg);
        result_next.in_range      = in_next;
        result_next.local_address = local_next;
        result_next.overrun       = in_next && (sat_next
            || (({1'b0, local_next} + (LOCAL_W+1)'(m3_side_reg.access_size))
                > {1'b0, mem_size_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/core/iad_chk.sv =====
// port checker for the interleaved address decoder, bound to the top level
// depends on iad_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "interleaved_address_decoder_assert.svh"
module iad_chk #(
    parameter int ADDR_WIDTH = iad_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              done,
    input  wire iad_pkg::result_t  result
);
    import iad_pkg::*;

    localparam int LAT = ADDR_WIDTH + 5;

    `IAD_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `IAD_ASSERT_NOW(a_done_has_source, clk, rst_n, done, $past(start, LAT))
    `IAD_ASSERT_NOW(a_miss_is_zero, clk, rst_n, done && !result.in_range, result.local_address == '0 && !result.overrun)
    `IAD_ASSERT_NOW(a_overrun_owned, clk, rst_n, done && result.overrun, result.in_range)

endmodule

bind interleaved_address_decoder iad_chk #(
    .ADDR_WIDTH (ADDR_WIDTH)
) u_iad_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

// ===== bench/tb_interleaved_address_decoder.sv =====
// testbench for the interleaved address decoder: directed table, then random settings
// and requests, each result checked against a table value or an in-bench decode of the address
// depends on iad_pkg and interleaved_address_decoder
`timescale 1ns / 1ps
`default_nettype none
module tb_interleaved_address_decoder;
    import iad_pkg::*;

    localparam int AW = ADDR_WIDTH_DEF;
    localparam int LATENCY = AW + 5;
    localparam logic [63:0] ADDR_MASK = ~64'd0 >> (64 - AW);
    localparam logic [63:0] LOCAL_MAX = (64'd1 << LOCAL_W) - 64'd1;

    typedef struct {
        bit          is_write;
        cfg_reg_t    reg_idx;
        logic [63:0] value;
        logic [SIZE_W-1:0] size;
        bit          typed;
        result_t     outcome;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    request_t request;
    logic done;
    result_t result;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [63:0]        base_q;
    logic [LOCAL_W-1:0] mem_size_q;
    logic [LOCAL_W-1:0] chunk_q;
    logic [LOCAL_W-1:0] stride_q;
    logic [PAGE_W-1:0]  pages_q;

    result_t   pending_decodes[$];
    stim_row_t dir_rows[$];
    int        errors = 0;
    int        idle_pct = 35;

    interleaved_address_decoder uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t decode_address(logic [63:0] raw_addr, logic [SIZE_W-1:0] size);
        logic [63:0] addr;
        logic [63:0] base;
        logic [63:0] gap;
        logic [63:0] page;
        logic [63:0] off;
        logic [63:0] loc;
        bit ok;
        bit sat;
        result_t r;
        addr = raw_addr & ADDR_MASK;
        base = base_q & ADDR_MASK;
        ok = 0;
        sat = 0;
        loc = 0;
        if (addr >= base)
        begin
            gap = addr - base;
            if (pages_q == 0)
            begin
                if (gap < 64'(mem_size_q))
                begin
                    ok = 1;
                    loc = gap;
                end
            end
            else if (stride_q != 0 && chunk_q != 0)
            begin
                page = gap / 64'(stride_q);
                off = gap % 64'(stride_q);
                if (page < 64'(pages_q) && off < 64'(chunk_q))
                begin
                    ok = 1;
                    if (page > (LOCAL_MAX - off) / 64'(chunk_q))
                    begin
                        sat = 1;
                        loc = LOCAL_MAX;
                    end
                    else
                        loc = page * 64'(chunk_q) + off;
                end
            end
        end
        r.in_range = ok;
        r.local_address = ok ? loc[LOCAL_W-1:0] : '0;
        r.overrun = ok && (sat || loc + 64'(size) > 64'(mem_size_q));
        return r;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                want = pending_decodes[0];
                pending_decodes.delete(0);
                if (result.in_range !== want.in_range)
                begin
                    $error("in_range expected %0d actual %0d", want.in_range, result.in_range);
                    errors++;
                end
                if (result.local_address !== want.local_address)
                begin
                    $error("local_address expected %0h actual %0h",
                           want.local_address, result.local_address);
                    errors++;
                end
                if (result.overrun !== want.overrun)
                begin
                    $error("overrun expected %0d actual %0d", want.overrun, result.overrun);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        @(negedge clk);
        start = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        case (idx)
            REG_RANGE_START:     base_q = value;
            REG_MEM_SIZE:        mem_size_q = value[LOCAL_W-1:0];
            REG_INTERLEAVE_SIZE: chunk_q = value[LOCAL_W-1:0];
            REG_INTERLEAVE_STEP: stride_q = value[LOCAL_W-1:0];
            REG_PAGE_COUNT:      pages_q = value[PAGE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        wait (pending_decodes.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic send_request(logic [63:0] addr, logic [SIZE_W-1:0] size, bit typed,
                                result_t outcome);
        bit taken;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            if ($urandom_range(99) < idle_pct)
                start = 1'b0;
            else
            begin
                start = 1'b1;
                request.request_address = addr;
                request.access_size = size;
                @(posedge clk);
                if (!busy)
                begin
                    taken = 1;
                    pending_decodes.insert(pending_decodes.size(),
                                           typed ? outcome : decode_address(addr, size));
                end
            end
        end
    endtask

    task automatic add_write(cfg_reg_t idx, logic [63:0] value);
        stim_row_t row;
        row = '{1, idx, value, '0, 0, '0};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic add_req(logic [63:0] addr, logic [SIZE_W-1:0] size, bit typed,
                           result_t outcome);
        stim_row_t row;
        row = '{0, REG_RANGE_START, addr, size, typed, outcome};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic random_setting(int phase);
        logic [63:0] rs;
        logic [63:0] chunk;
        logic [63:0] stride;
        logic [63:0] pages;
        rs = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            rs = rs & 64'hFFFF;
        if (phase == 0)
        begin
            write_reg(REG_RANGE_START, '1);
            write_reg(REG_MEM_SIZE, '1);
            write_reg(REG_INTERLEAVE_SIZE, '1);
            write_reg(REG_INTERLEAVE_STEP, '1);
            write_reg(REG_PAGE_COUNT, '1);
            return;
        end
        if (phase == 1)
        begin
            write_reg(REG_RANGE_START, '0);
            write_reg(REG_MEM_SIZE, LOCAL_MAX);
            write_reg(REG_INTERLEAVE_SIZE, '0);
            write_reg(REG_INTERLEAVE_STEP, '0);
            write_reg(REG_PAGE_COUNT, '0);
            return;
        end
        chunk = $urandom_range(1, 64);
        stride = chunk + $urandom_range(0, 64);
        pages = (phase % 4 == 3) ? 0 : $urandom_range(1, 16);
        if (phase % 5 == 4)
            stride = 0;
        write_reg(REG_RANGE_START, rs);
        write_reg(REG_INTERLEAVE_SIZE, chunk);
        write_reg(REG_INTERLEAVE_STEP, stride);
        write_reg(REG_PAGE_COUNT, pages);
        write_reg(REG_MEM_SIZE, (pages == 0 ? 64'd256 : pages * chunk)
                                + $urandom_range(0, 32) - 16);
    endtask

    initial
    begin
        result_t none;
        result_t hit;
        logic [63:0] addr;
        logic [63:0] span;
        logic [SIZE_W-1:0] size;
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        base_q = '0;
        mem_size_q = '0;
        chunk_q = '0;
        stride_q = '0;
        pages_q = '0;

        // after reset nothing is owned
        add_req(64'd0, 13'd0, 1, none);
        add_req('1, 13'd4096, 1, none);
        // flat window
        add_write(REG_RANGE_START, 64'h1000);
        add_write(REG_MEM_SIZE, 64'h100);
        hit = '{1'b1, 53'h0, 1'b0};
        add_req(64'h1000, 13'd0, 1, hit);
        add_req(64'h10FF, 13'd1, 1, '{1'b1, 53'hFF, 1'b0});
        add_req(64'h10FF, 13'd2, 1, '{1'b1, 53'hFF, 1'b1});
        add_req(64'h1100, 13'd0, 1, none);
        add_req(64'h0FFF, 13'd1, 1, none);
        // window at the top of the address space does not wrap
        add_write(REG_RANGE_START, 64'hFFFF_FFFF_FFFF_FF00);
        add_write(REG_MEM_SIZE, 64'h1000);
        add_req(64'd0, 13'd0, 1, none);
        add_req('1, '1, 1, '{1'b1, 53'hFF, 1'b1});
        // interleaved
        add_write(REG_RANGE_START, 64'd0);
        add_write(REG_INTERLEAVE_SIZE, 64'h40);
        add_write(REG_INTERLEAVE_STEP, 64'h100);
        add_write(REG_PAGE_COUNT, 64'd4);
        add_req(64'h13F, 13'd1, 0, none);
        add_req(64'h140, 13'd1, 0, none);
        add_req(64'h33F, 13'd64, 0, none);
        add_req(64'h400, 13'd0, 0, none);
        // zero stride
        add_write(REG_INTERLEAVE_STEP, 64'd0);
        add_req(64'h10, 13'd0, 1, none);
        // zero chunk size
        add_write(REG_INTERLEAVE_STEP, 64'h100);
        add_write(REG_INTERLEAVE_SIZE, 64'd0);
        add_req(64'h10, 13'd0, 1, none);
        // local address saturates
        add_write(REG_INTERLEAVE_SIZE, 64'd1 << 52);
        add_write(REG_INTERLEAVE_STEP, 64'd1 << 52);
        add_write(REG_PAGE_COUNT, 64'd1000);
        add_req(64'd1 << 54, 13'd0, 1, '{1'b1, LOCAL_MAX[LOCAL_W-1:0], 1'b1});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                drain();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                send_request(dir_rows[i].value, dir_rows[i].size, dir_rows[i].typed,
                             dir_rows[i].outcome);
        end

        for (int phase = 0; phase < 12; phase++)
        begin
            drain();
            random_setting(phase);
            idle_pct = (phase == 5) ? 0 : 35;
            if (pages_q == 0)
                span = 64'(mem_size_q);
            else
                span = 64'(stride_q) * 64'(pages_q);
            if (span > 64'hFFFF || span == 0)
                span = 64'h1000;
            for (int n = 0; n < 160; n++)
            begin
                if (phase == 7 && n == 80)
                    drain();
                if ($urandom_range(3) == 0)
                    addr = {$urandom, $urandom};
                else
                    addr = base_q + $urandom_range(0, 32'(span + span / 4))
                           - $urandom_range(0, 4);
                size = ($urandom_range(7) == 0) ? SIZE_W'($urandom)
                                                : SIZE_W'($urandom_range(0, 4096));
                send_request(addr, size, 0, none);
            end
        end

        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/iad_pkg.sv
rtl/core/iad_div.sv
rtl/core/interleaved_address_decoder.sv
rtl/core/iad_chk.sv
bench/tb_interleaved_address_decoder.sv
